/* rtl/core/best_fit_resource_allocator_unit_macros.svh */
// Assertion helpers used by the allocator top-level RTL.
`ifndef BEST_FIT_RESOURCE_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_RESOURCE_ALLOCATOR_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the trigger.
`define BFRA_ASSERT_SAME(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("allocator check failed: same-cycle rule");

// Consequence must hold in the cycle after the trigger.
`define BFRA_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("allocator check failed: next-cycle rule");

`endif

/* rtl/core/bfra_pkg.sv */
package bfra_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int KIND_W = 2;
    localparam int ID_W   = 16;
    localparam int CAP_W  = 10;
    localparam int TIME_W = 32;
    localparam int STAT_W = 3;

    localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHK = 2'd2;

    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_ALLOC    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd4;
    localparam logic [STAT_W-1:0] ST_RELEASED = 3'd5;
    localparam logic [STAT_W-1:0] ST_NOTDUE   = 3'd6;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [CAP_W-1:0]  capacity;
        logic              free;
        logic [TIME_W-1:0] release_time;
    } slot_row_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/bfra_if.sv */
interface bfra_in_if;
    logic                          valid;
    logic                          ready;
    logic [bfra_pkg::KIND_W-1:0]   kind;
    logic [bfra_pkg::ID_W-1:0]     resource_id;
    logic [bfra_pkg::CAP_W-1:0]    resource_size;
    logic [bfra_pkg::CAP_W-1:0]    amount_needed;
    logic [bfra_pkg::TIME_W-1:0]   end_time;
    logic [bfra_pkg::TIME_W-1:0]   now_time;

    modport source (
        output valid, kind, resource_id, resource_size, amount_needed, end_time, now_time,
        input  ready
    );
    modport sink (
        input  valid, kind, resource_id, resource_size, amount_needed, end_time, now_time,
        output ready
    );
endinterface

interface bfra_out_if;
    logic                        valid;
    logic                        ready;
    logic [bfra_pkg::STAT_W-1:0] status;
    logic [bfra_pkg::ID_W-1:0]   chosen_id;

    modport source (
        output valid, status, chosen_id,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_id,
        output ready
    );
endinterface

/* rtl/core/best_fit_resource_allocator_unit.sv */
// Best-fit resource allocator with timed release. The unit holds a table of
// SLOTS resources (id, capacity, free mark, release time). An add item puts a
// new free resource in the lowest unused slot unless its id is already present
// (duplicate) or no slot is left (full). A request item takes the free
// resource with the smallest capacity that covers amount_needed, lowest slot on
// ties, and keeps it busy until end_time. A check item frees the busy resource
// with the earliest release time (lowest id on ties) if that time is at or
// before now_time. Kind 3 changes nothing and answers "nothing due". Every
// item returns exactly one result item on rsp. Items are handled one at a
// time: after acceptance the unit scans the slot table through its single
// read port, one slot per cycle, then drains the last read into the compare
// stage and commits, writing the table and loading the result register. The
// commit waits while an earlier result is still held off by rsp.ready. The
// next item is taken as soon as the result is loaded into the output
// register, even while that result waits for rsp.ready. After reset the
// table is empty and the unit is ready at once.

`include "best_fit_resource_allocator_unit_macros.svh"

module best_fit_resource_allocator_unit #(
    parameter int SLOTS = bfra_pkg::SLOTS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    bfra_in_if.sink    cmd,
    bfra_out_if.source rsp
);

    localparam int IW = $clog2(SLOTS);

    bfra_pkg::dp_cmd_t  dp_cmd;
    bfra_pkg::dp_stat_t dp_stat;
    logic [IW-1:0]      rd_addr;

    // Sequencer: accept, walk the table, settle, commit.
    bfra_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .cmd      (dp_cmd),
        .rd_addr  (rd_addr),
        .stat     (dp_stat)
    );

    // Table, best-fit and earliest-release search, result register.
    bfra_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (cmd.kind),
        .resource_id   (cmd.resource_id),
        .resource_size (cmd.resource_size),
        .amount_needed (cmd.amount_needed),
        .end_time      (cmd.end_time),
        .now_time      (cmd.now_time),
        .cmd           (dp_cmd),
        .rd_addr       (rd_addr),
        .stat          (dp_stat),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .status        (rsp.status),
        .chosen_id     (rsp.chosen_id)
    );

    // An accepted item closes the input until its result is committed.
    `BFRA_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready)
    // A commit always presents a result on the next cycle.
    `BFRA_ASSERT_NEXT(a_commit_shows_result, dp_cmd.commit, rsp.valid)
    // Never commit over a result that is still waiting.
    `BFRA_ASSERT_SAME(a_commit_room, dp_cmd.commit, !rsp.valid || rsp.ready)
    // Table reads belong to the scan only, never to an idle unit.
    `BFRA_ASSERT_SAME(a_scan_not_idle, dp_cmd.rd_en, !cmd.ready)

endmodule

/* rtl/core/bfra_ctrl.sv */
module bfra_ctrl #(
    parameter int SLOTS = bfra_pkg::SLOTS_DEFAULT,
    localparam int IW   = $clog2(SLOTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output bfra_pkg::dp_cmd_t  cmd,
    output logic [IW-1:0]      rd_addr,
    input  bfra_pkg::dp_stat_t stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == IW'(SLOTS - 1))
                    state_next = S_DRAIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DRAIN:
            begin
                // let the last slot read reach the compare stage
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/core/bfra_datapath.sv */
module bfra_datapath #(
    parameter int SLOTS = bfra_pkg::SLOTS_DEFAULT,
    localparam int IW   = $clog2(SLOTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bfra_pkg::KIND_W-1:0]   kind,
    input  logic [bfra_pkg::ID_W-1:0]     resource_id,
    input  logic [bfra_pkg::CAP_W-1:0]    resource_size,
    input  logic [bfra_pkg::CAP_W-1:0]    amount_needed,
    input  logic [bfra_pkg::TIME_W-1:0]   end_time,
    input  logic [bfra_pkg::TIME_W-1:0]   now_time,
    input  bfra_pkg::dp_cmd_t             cmd,
    input  logic [IW-1:0]                 rd_addr,
    output bfra_pkg::dp_stat_t            stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bfra_pkg::STAT_W-1:0]   status,
    output logic [bfra_pkg::ID_W-1:0]     chosen_id
);

    // held item
    logic [bfra_pkg::KIND_W-1:0] kind_reg;
    logic [bfra_pkg::ID_W-1:0]   key_id_reg;
    logic [bfra_pkg::CAP_W-1:0]  size_reg;
    logic [bfra_pkg::CAP_W-1:0]  need_reg;
    logic [bfra_pkg::TIME_W-1:0] until_reg;
    logic [bfra_pkg::TIME_W-1:0] now_reg;

    // slot table
    bfra_pkg::slot_row_t mem [SLOTS];
    logic [SLOTS-1:0]    used_reg;

    // read stage
    bfra_pkg::slot_row_t rd_row_reg;
    logic                rd_used_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic                rd_valid_reg;

    // running search results
    logic                dup_reg, spot_found_reg, found_reg;
    logic [IW-1:0]       spot_idx_reg, best_idx_reg;
    bfra_pkg::slot_row_t best_row_reg;

    // result register
    logic                          out_valid_reg;
    logic [bfra_pkg::STAT_W-1:0]   status_reg;
    logic [bfra_pkg::ID_W-1:0]     chosen_reg;

    logic                hit_dup, take_spot, req_cand, chk_cand;
    logic                req_better, chk_better, take_best;
    logic                mem_we, set_used;
    logic [IW-1:0]       waddr;
    bfra_pkg::slot_row_t wrow;
    logic [bfra_pkg::STAT_W-1:0] st_next;
    logic [bfra_pkg::ID_W-1:0]   cid_next;

    // compare stage
    always_comb
    begin
        hit_dup    = rd_valid_reg && rd_used_reg && (rd_row_reg.ident == key_id_reg);
        take_spot  = rd_valid_reg && !rd_used_reg && !spot_found_reg;
        req_cand   = rd_used_reg && rd_row_reg.free && (rd_row_reg.capacity >= need_reg);
        chk_cand   = rd_used_reg && !rd_row_reg.free;
        req_better = !found_reg || (rd_row_reg.capacity < best_row_reg.capacity);
        chk_better = !found_reg
                     || (rd_row_reg.release_time < best_row_reg.release_time)
                     || ((rd_row_reg.release_time == best_row_reg.release_time)
                         && (rd_row_reg.ident < best_row_reg.ident));
        take_best  = rd_valid_reg
                     && (((kind_reg == bfra_pkg::KIND_REQ) && req_cand && req_better)
                      || ((kind_reg == bfra_pkg::KIND_CHK) && chk_cand && chk_better));
    end

    // decision at commit
    always_comb
    begin
        st_next  = bfra_pkg::ST_NOTDUE;
        cid_next = '0;
        mem_we   = 1'b0;
        set_used = 1'b0;
        waddr    = best_idx_reg;
        wrow     = best_row_reg;
        case (kind_reg)
            bfra_pkg::KIND_ADD:
            begin
                if (dup_reg)
                    st_next = bfra_pkg::ST_DUP;
                else if (!spot_found_reg)
                    st_next = bfra_pkg::ST_FULL;
                else
                begin
                    st_next           = bfra_pkg::ST_ADDED;
                    mem_we            = cmd.commit;
                    set_used          = cmd.commit;
                    waddr             = spot_idx_reg;
                    wrow.ident        = key_id_reg;
                    wrow.capacity     = size_reg;
                    wrow.free         = 1'b1;
                    wrow.release_time = '0;
                end
            end
            bfra_pkg::KIND_REQ:
            begin
                if (found_reg)
                begin
                    st_next           = bfra_pkg::ST_ALLOC;
                    cid_next          = best_row_reg.ident;
                    mem_we            = cmd.commit;
                    wrow.free         = 1'b0;
                    wrow.release_time = until_reg;
                end
                else
                    st_next = bfra_pkg::ST_NOFIT;
            end
            bfra_pkg::KIND_CHK:
            begin
                if (found_reg && (best_row_reg.release_time <= now_reg))
                begin
                    st_next   = bfra_pkg::ST_RELEASED;
                    cid_next  = best_row_reg.ident;
                    mem_we    = cmd.commit;
                    wrow.free = 1'b1;
                end
            end
            default:
            begin
                st_next = bfra_pkg::ST_NOTDUE;
            end
        endcase
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wrow;
        if (cmd.rd_en)
            rd_row_reg <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            key_id_reg <= resource_id;
            size_reg   <= resource_size;
            need_reg   <= amount_needed;
            until_reg  <= end_time;
            now_reg    <= now_time;
        end
        if (cmd.rd_en)
            rd_idx_reg <= rd_addr;
        if (take_spot)
            spot_idx_reg <= rd_idx_reg;
        if (take_best)
        begin
            best_idx_reg <= rd_idx_reg;
            best_row_reg <= rd_row_reg;
        end
        if (cmd.commit)
        begin
            status_reg <= st_next;
            chosen_reg <= cid_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            rd_used_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            dup_reg        <= 1'b0;
            spot_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.rd_en)
                rd_used_reg <= used_reg[rd_addr];
            if (set_used)
                used_reg[waddr] <= 1'b1;
            if (cmd.load)
            begin
                dup_reg        <= 1'b0;
                spot_found_reg <= 1'b0;
                found_reg      <= 1'b0;
            end
            else
            begin
                if (hit_dup)
                    dup_reg <= 1'b1;
                if (take_spot)
                    spot_found_reg <= 1'b1;
                if (take_best)
                    found_reg <= 1'b1;
            end
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign chosen_id     = chosen_reg;

endmodule

/* dv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_SLOTS   = bfra_pkg::SLOTS_DEFAULT;
    localparam int RAND_ITEMS  = 1750;
    localparam int CYCLE_LIMIT = 400000;

    // The package names only the three live kinds; the fourth is a no-op.
    localparam logic [bfra_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [bfra_pkg::KIND_W-1:0] kind;
        logic [bfra_pkg::ID_W-1:0]   resource_id;
        logic [bfra_pkg::CAP_W-1:0]  resource_size;
        logic [bfra_pkg::CAP_W-1:0]  amount_needed;
        logic [bfra_pkg::TIME_W-1:0] end_time;
        logic [bfra_pkg::TIME_W-1:0] now_time;
    } cmd_item_t;

    typedef struct packed {
        logic [bfra_pkg::STAT_W-1:0] status;
        logic [bfra_pkg::ID_W-1:0]   ident;
    } alloc_result_t;

    // One row of the directed sequence. A row with rep > 1 adds a run of
    // consecutive ids with random capacities. Rows with typed set carry an
    // outcome that is obvious by inspection; the rest rely on the predictor.
    typedef struct packed {
        logic [bfra_pkg::KIND_W-1:0] kind;
        logic [bfra_pkg::ID_W-1:0]   resource_id;
        logic [bfra_pkg::CAP_W-1:0]  resource_size;
        logic [bfra_pkg::CAP_W-1:0]  amount_needed;
        logic [bfra_pkg::TIME_W-1:0] end_time;
        logic [bfra_pkg::TIME_W-1:0] now_time;
        int                          rep;
        bit                          typed;
        logic [bfra_pkg::STAT_W-1:0] want_status;
        logic [bfra_pkg::ID_W-1:0]   want_id;
    } stim_row_t;

    localparam int DIR_ROWS = 24;

    stim_row_t dir_tab [DIR_ROWS] = '{
        // empty table: nothing to release, nothing to grant, spare kind
        '{bfra_pkg::KIND_CHK, 16'h0000, 10'd0, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_NOTDUE, 16'h0000},
        '{bfra_pkg::KIND_REQ, 16'h0000, 10'd0, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_NOFIT, 16'h0000},
        '{KIND_SPARE, 16'hffff, 10'h3ff, 10'h3ff, 32'hffffffff, 32'hffffffff, 1, 1'b1,
          bfra_pkg::ST_NOTDUE, 16'h0000},
        // extremes of id and capacity, duplicate on a free entry
        '{bfra_pkg::KIND_ADD, 16'h0000, 10'd0, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_ADDED, 16'h0000},
        '{bfra_pkg::KIND_ADD, 16'h0000, 10'h3ff, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_DUP, 16'h0000},
        '{bfra_pkg::KIND_ADD, 16'hffff, 10'h3ff, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_ADDED, 16'h0000},
        '{bfra_pkg::KIND_REQ, 16'h0000, 10'd0, 10'h3ff, 32'hffffffff, 32'h0, 1, 1'b1,
          bfra_pkg::ST_ALLOC, 16'hffff},
        // duplicate on a busy entry
        '{bfra_pkg::KIND_ADD, 16'hffff, 10'd5, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_DUP, 16'h0000},
        // zero amount takes the zero-capacity entry, then nothing is left
        '{bfra_pkg::KIND_REQ, 16'h0000, 10'd0, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_ALLOC, 16'h0000},
        '{bfra_pkg::KIND_REQ, 16'h0000, 10'd0, 10'd0, 32'h7, 32'h0, 1, 1'b1,
          bfra_pkg::ST_NOFIT, 16'h0000},
        // release time equal to now is due; one short of the maximum is not
        '{bfra_pkg::KIND_CHK, 16'h0000, 10'd0, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_RELEASED, 16'h0000},
        '{bfra_pkg::KIND_CHK, 16'h0000, 10'd0, 10'd0, 32'h0, 32'hfffffffe, 1, 1'b1,
          bfra_pkg::ST_NOTDUE, 16'h0000},
        '{bfra_pkg::KIND_CHK, 16'h0000, 10'd0, 10'd0, 32'h0, 32'hffffffff, 1, 1'b1,
          bfra_pkg::ST_RELEASED, 16'hffff},
        // best-fit tie on capacity goes to the lower slot
        '{bfra_pkg::KIND_ADD, 16'h1234, 10'd200, 10'd0, 32'h0, 32'h0, 1, 1'b0,
          bfra_pkg::ST_ADDED, 16'h0000},
        '{bfra_pkg::KIND_ADD, 16'h0007, 10'd100, 10'd0, 32'h0, 32'h0, 1, 1'b0,
          bfra_pkg::ST_ADDED, 16'h0000},
        '{bfra_pkg::KIND_ADD, 16'h0003, 10'd100, 10'd0, 32'h0, 32'h0, 1, 1'b0,
          bfra_pkg::ST_ADDED, 16'h0000},
        '{bfra_pkg::KIND_REQ, 16'h0000, 10'd0, 10'd50, 32'd10, 32'h0, 1, 1'b0,
          bfra_pkg::ST_ALLOC, 16'h0000},
        '{bfra_pkg::KIND_REQ, 16'h0000, 10'd0, 10'd50, 32'd10, 32'h0, 1, 1'b0,
          bfra_pkg::ST_ALLOC, 16'h0000},
        // release tie on time goes to the lower id
        '{bfra_pkg::KIND_CHK, 16'h0000, 10'd0, 10'd0, 32'h0, 32'd9, 1, 1'b0,
          bfra_pkg::ST_NOTDUE, 16'h0000},
        '{bfra_pkg::KIND_CHK, 16'h0000, 10'd0, 10'd0, 32'h0, 32'd10, 1, 1'b0,
          bfra_pkg::ST_RELEASED, 16'h0000},
        // fill the rest of the table, then hit the full and duplicate checks
        '{bfra_pkg::KIND_ADD, 16'h0100, 10'd0, 10'd0, 32'h0, 32'h0, 11, 1'b0,
          bfra_pkg::ST_ADDED, 16'h0000},
        '{bfra_pkg::KIND_ADD, 16'h2000, 10'd1, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_FULL, 16'h0000},
        '{bfra_pkg::KIND_ADD, 16'h0000, 10'd1, 10'd0, 32'h0, 32'h0, 1, 1'b1,
          bfra_pkg::ST_DUP, 16'h0000},
        '{bfra_pkg::KIND_REQ, 16'h0000, 10'd0, 10'h3ff, 32'd20, 32'h0, 1, 1'b0,
          bfra_pkg::ST_ALLOC, 16'h0000}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;

    bfra_in_if  cmd_if ();
    bfra_out_if rsp_if ();

    assign rsp_if.ready = sink_ready;

    best_fit_resource_allocator_unit #(
        .SLOTS (TBL_SLOTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the resource table, kept in step with accepted items.
    bit                  tbl_used [TBL_SLOTS];
    bfra_pkg::slot_row_t tbl_row  [TBL_SLOTS];
    alloc_result_t       pending_outcomes [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_len        = 0;
    int pattern_mode   = 0;
    int pattern_left   = 0;
    int pattern_phase  = 0;

    // Advance the shadow table by one item and return the outcome it causes.
    function automatic alloc_result_t predict_alloc(cmd_item_t it);
        alloc_result_t r;
        int            spot;
        int            best;
        bit            dup;
        r.status = bfra_pkg::ST_NOTDUE;
        r.ident  = '0;
        spot     = -1;
        best     = -1;
        dup      = 1'b0;
        case (it.kind)
            bfra_pkg::KIND_ADD:
            begin
                // Duplicate test covers free and busy entries and wins over full.
                for (int k = 0; k < TBL_SLOTS; k++)
                begin
                    if (tbl_used[k] && tbl_row[k].ident == it.resource_id)
                        dup = 1'b1;
                    if (!tbl_used[k] && spot < 0)
                        spot = k;
                end
                if (dup)
                    r.status = bfra_pkg::ST_DUP;
                else if (spot < 0)
                    r.status = bfra_pkg::ST_FULL;
                else
                begin
                    tbl_used[spot]             = 1'b1;
                    tbl_row[spot].ident        = it.resource_id;
                    tbl_row[spot].capacity     = it.resource_size;
                    tbl_row[spot].free         = 1'b1;
                    tbl_row[spot].release_time = '0;
                    r.status                   = bfra_pkg::ST_ADDED;
                end
            end
            bfra_pkg::KIND_REQ:
            begin
                // Strict less-than keeps the lowest slot on a capacity tie.
                for (int k = 0; k < TBL_SLOTS; k++)
                begin
                    if (tbl_used[k] && tbl_row[k].free &&
                        tbl_row[k].capacity >= it.amount_needed)
                    begin
                        if (best < 0)
                            best = k;
                        else if (tbl_row[k].capacity < tbl_row[best].capacity)
                            best = k;
                    end
                end
                if (best < 0)
                    r.status = bfra_pkg::ST_NOFIT;
                else
                begin
                    tbl_row[best].free         = 1'b0;
                    tbl_row[best].release_time = it.end_time;
                    r.status                   = bfra_pkg::ST_ALLOC;
                    r.ident                    = tbl_row[best].ident;
                end
            end
            bfra_pkg::KIND_CHK:
            begin
                // Earliest release time first, lowest id on a time tie.
                for (int k = 0; k < TBL_SLOTS; k++)
                begin
                    if (tbl_used[k] && !tbl_row[k].free)
                    begin
                        if (best < 0)
                            best = k;
                        else if (tbl_row[k].release_time < tbl_row[best].release_time ||
                                 (tbl_row[k].release_time == tbl_row[best].release_time &&
                                  tbl_row[k].ident < tbl_row[best].ident))
                            best = k;
                    end
                end
                if (best >= 0 && tbl_row[best].release_time <= it.now_time)
                begin
                    tbl_row[best].free = 1'b1;
                    r.status           = bfra_pkg::ST_RELEASED;
                    r.ident            = tbl_row[best].ident;
                end
            end
            default:
                r.status = bfra_pkg::ST_NOTDUE;
        endcase
        return r;
    endfunction

    // Present one item, hold it until the unit takes it, then log what it
    // should produce. Between bursts drop valid for a random gap.
    task automatic issue_item(input cmd_item_t it, input bit typed,
                              input alloc_result_t want);
        alloc_result_t pred;
        cmd_if.valid         <= 1'b1;
        cmd_if.kind          <= it.kind;
        cmd_if.resource_id   <= it.resource_id;
        cmd_if.resource_size <= it.resource_size;
        cmd_if.amount_needed <= it.amount_needed;
        cmd_if.end_time      <= it.end_time;
        cmd_if.now_time      <= it.now_time;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        pred = predict_alloc(it);
        if (typed)
            pred = want;
        pending_outcomes = {pending_outcomes, pred};
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            // Mostly short bursts, now and then a long stretch with no gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
    endtask

    // Receiver: switch at random among always-ready, coin-flip, three-in-four
    // and half-period stall patterns.
    always @(posedge clk)
    begin
        if (pattern_left == 0)
        begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        pattern_phase++;
        case (pattern_mode)
            0:       sink_ready <= 1'b1;
            1:       sink_ready <= 1'($urandom_range(0, 1));
            2:       sink_ready <= (pattern_phase % 4 != 0);
            default: sink_ready <= !pattern_phase[3];
        endcase
    end

    // Compare every result item taken against the oldest outcome waiting.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result item: expected none, actual status %0d chosen_id %h",
                         $time, rsp_if.status, rsp_if.chosen_id);
            end
            else
            begin
                if (rsp_if.status !== pending_outcomes[0].status)
                begin
                    mismatch_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, pending_outcomes[0].status, rsp_if.status);
                end
                if (rsp_if.chosen_id !== pending_outcomes[0].ident)
                begin
                    mismatch_count++;
                    $display("%0t: chosen_id mismatch: expected %h, actual %h",
                             $time, pending_outcomes[0].ident, rsp_if.chosen_id);
                end
                void'(pending_outcomes.pop_front());
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[best_fit_resource_allocator_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        cmd_item_t                   it;
        alloc_result_t               want;
        stim_row_t                   row;
        int                          pick;
        logic [bfra_pkg::TIME_W-1:0] sim_now;

        cmd_if.valid         = 1'b0;
        cmd_if.kind          = '0;
        cmd_if.resource_id   = '0;
        cmd_if.resource_size = '0;
        cmd_if.amount_needed = '0;
        cmd_if.end_time      = '0;
        cmd_if.now_time      = '0;
        sim_now              = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence: walk the table, expanding runs of adds.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            for (int r = 0; r < row.rep; r++)
            begin
                it.kind          = row.kind;
                it.resource_id   = row.resource_id + bfra_pkg::ID_W'(r);
                it.resource_size = (row.rep > 1)
                                   ? bfra_pkg::CAP_W'($urandom_range(0, 1023))
                                   : row.resource_size;
                it.amount_needed = row.amount_needed;
                it.end_time      = row.end_time;
                it.now_time      = row.now_time;
                want.status      = row.want_status;
                want.ident       = row.want_id;
                issue_item(it, row.typed, want);
            end
        end

        // Random traffic against a moving notion of "now". End times land
        // on a coarse grid ahead of it so release ties occur; a share of
        // items uses full-range values for every field.
        want = '0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            it.resource_id   = bfra_pkg::ID_W'($urandom);
            it.resource_size = bfra_pkg::CAP_W'($urandom);
            it.amount_needed = bfra_pkg::CAP_W'($urandom);
            it.end_time      = $urandom;
            it.now_time      = $urandom;
            pick             = $urandom_range(0, TBL_SLOTS - 1);
            case ($urandom_range(0, 99)) inside
                [0:7]:
                begin
                    it.kind = bfra_pkg::KIND_ADD;
                    // Half the adds reuse a live id, when the picked slot is in use, to hit the duplicate path.
                    if ($urandom_range(0, 1) == 0 && tbl_used[pick])
                        it.resource_id = tbl_row[pick].ident;
                end
                [8:52]:
                begin
                    it.kind = bfra_pkg::KIND_REQ;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4:
                            if (tbl_used[pick])
                                it.amount_needed = tbl_row[pick].capacity;
                        5:  it.amount_needed = '0;
                        6:  it.amount_needed = '1;
                        7:
                            if (tbl_used[pick])
                                it.amount_needed = tbl_row[pick].capacity + 1'b1;
                        default: ;
                    endcase
                    if ($urandom_range(0, 99) < 85)
                        it.end_time = sim_now
                                      + bfra_pkg::TIME_W'(4 * $urandom_range(0, 16));
                end
                [53:94]:
                begin
                    it.kind = bfra_pkg::KIND_CHK;
                    if ($urandom_range(0, 99) < 85)
                    begin
                        it.now_time = sim_now;
                        sim_now     = sim_now + bfra_pkg::TIME_W'($urandom_range(0, 12));
                    end
                end
                default:
                    it.kind = KIND_SPARE;
            endcase
            issue_item(it, 1'b0, want);

            // Halfway through, hold off until every outcome has drained.
            if (n == RAND_ITEMS / 2)
            begin
                cmd_if.valid <= 1'b0;
                while (pending_outcomes.size() != 0)
                    @(posedge clk);
            end
        end

        cmd_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        // Watch a while longer for stray result items.
        repeat (2 * (TBL_SLOTS + 3)) @(posedge clk);

        if (mismatch_count == 0)
            $display("[best_fit_resource_allocator_unit] OK");
        else
            $display("[best_fit_resource_allocator_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bfra_pkg.sv
rtl/core/bfra_if.sv
rtl/core/bfra_ctrl.sv
rtl/core/bfra_datapath.sv
rtl/core/best_fit_resource_allocator_unit.sv
dv/tb_top.sv
